// ----- rtl/tbh_pkg.sv -----
// package: types and rom for the table byte hash
package tbh_pkg;

  localparam int unsigned HashW = 64;
  localparam int unsigned ByteW = 8;
  localparam int unsigned RomDepth = 256;

  typedef logic [HashW-1:0] hash_t;
  typedef logic [ByteW-1:0] byte_t;

  typedef struct packed {
    byte_t data_byte;
    logic  start_req;
    hash_t seed;
    logic  last_byte;
  } in_item_t;

  typedef struct packed {
    hash_t hash_value;
    logic  is_final;
  } out_item_t;

  localparam hash_t HASH_ROM [RomDepth] = '{
    64'd7266447313870364031, 64'd4946485549665804864, 64'd16945909448695747420,
    64'd16394063075524226720, 64'd4873882236456199058, 64'd14877448043947020171,
    64'd6740343660852211943, 64'd13857871200353263164, 64'd5249110015610582907,
    64'd10205081126064480383, 64'd1235879089597390050, 64'd17320312680810499042,
    64'd16489141110565194782, 64'd8942268601720066061, 64'd13520575722002588570,
    64'd14226945236717732373, 64'd9383926873555417063, 64'd15690281668532552105,
    64'd11510704754157191257, 64'd15864264574919463609, 64'd6489677788245343319,
    64'd5112602299894754389, 64'd10828930062652518694, 64'd15942305434158995996,
    64'd15445717675088218264, 64'd4764500002345775851, 64'd14673753115101942098,
    64'd236502320419669032, 64'd13670483975188204088, 64'd14931360615268175698,
    64'd8904234204977263924, 64'd12836915408046564963, 64'd12120302420213647524,
    64'd15755110976537356441, 64'd5405758943702519480, 64'd10951858968426898805,
    64'd17251681303478610375, 64'd4144140664012008120, 64'd18286145806977825275,
    64'd13075804672185204371, 64'd10831805955733617705, 64'd6172975950399619139,
    64'd12837097014497293886, 64'd12903857913610213846, 64'd560691676108914154,
    64'd1074659097419704618, 64'd14266121283820281686, 64'd11696403736022963346,
    64'd13383246710985227247, 64'd7132746073714321322, 64'd10608108217231874211,
    64'd9027884570906061560, 64'd12893913769120703138, 64'd15675160838921962454,
    64'd2511068401785704737, 64'd14483183001716371453, 64'd3774730664208216065,
    64'd5083371700846102796, 64'd9583498264570933637, 64'd17119870085051257224,
    64'd5217910858257235075, 64'd10612176809475689857, 64'd1924700483125896976,
    64'd7171619684536160599, 64'd10949279256701751503, 64'd15596196964072664893,
    64'd14097948002655599357, 64'd615821766635933047, 64'd5636498760852923045,
    64'd17618792803942051220, 64'd580805356741162327, 64'd425267967796817241,
    64'd8381470634608387938, 64'd13212228678420887626, 64'd16993060308636741960,
    64'd957923366004347591, 64'd6210242862396777185, 64'd1012818702180800310,
    64'd15299383925974515757, 64'd17501832009465945633, 64'd17453794942891241229,
    64'd15807805462076484491, 64'd8407189590930420827, 64'd974125122787311712,
    64'd1861591264068118966, 64'd997568339582634050, 64'd18046771844467391493,
    64'd17981867688435687790, 64'd3809841506498447207, 64'd9460108917638135678,
    64'd16172980638639374310, 64'd958022432077424298, 64'd4393365126459778813,
    64'd13408683141069553686, 64'd13900005529547645957, 64'd15773550354402817866,
    64'd16475327524349230602, 64'd6260298154874769264, 64'd12224576659776460914,
    64'd6405294864092763507, 64'd7585484664713203306, 64'd5187641382818981381,
    64'd12435998400285353380, 64'd13554353441017344755, 64'd646091557254529188,
    64'd11393747116974949255, 64'd16797249248413342857, 64'd15713519023537495495,
    64'd12823504709579858843, 64'd4738086532119935073, 64'd4429068783387643752,
    64'd585582692562183870, 64'd1048280754023674130, 64'd6788940719869959076,
    64'd11670856244972073775, 64'd2488756775360218862, 64'd2061695363573180185,
    64'd6884655301895085032, 64'd3566345954323888697, 64'd12784319933059041817,
    64'd4772468691551857254, 64'd6864898938209826895, 64'd7198730565322227090,
    64'd2452224231472687253, 64'd13424792606032445807, 64'd10827695224855383989,
    64'd11016608897122070904, 64'd14683280565151378358, 64'd7077866519618824360,
    64'd17487079941198422333, 64'd3956319990205097495, 64'd5804870313319323478,
    64'd8017203611194497730, 64'd3310931575584983808, 64'd5009341981771541845,
    64'd11772020174577005930, 64'd3537640779967351792, 64'd6801855569284252424,
    64'd17687268231192623388, 64'd12968358613633237218, 64'd1429775571144180123,
    64'd10427377732172208413, 64'd12155566091986788996, 64'd16465954421598296115,
    64'd12710429690464359999, 64'd9547226351541565595, 64'd12156624891403410342,
    64'd2985938688676214686, 64'd18066917785985010959, 64'd5975570403614438776,
    64'd11541343163022500560, 64'd11115388652389704592, 64'd9499328389494710074,
    64'd9247163036769651820, 64'd3688303938005101774, 64'd2210483654336887556,
    64'd15458161910089693228, 64'd6558785204455557683, 64'd1288373156735958118,
    64'd18433986059948829624, 64'd3435082195390932486, 64'd16822351800343061990,
    64'd3120532877336962310, 64'd16681785111062885568, 64'd7835551710041302304,
    64'd2612798015018627203, 64'd15083279177152657491, 64'd6591467229462292195,
    64'd10592706450534565444, 64'd7438147750787157163, 64'd323186165595851698,
    64'd7444710627467609883, 64'd8473714411329896576, 64'd2782675857700189492,
    64'd3383567662400128329, 64'd3200233909833521327, 64'd12897601280285604448,
    64'd3612068790453735040, 64'd8324209243736219497, 64'd15789570356497723463,
    64'd1083312926512215996, 64'd4797349136059339390, 64'd5556729349871544986,
    64'd18266943104929747076, 64'd1620389818516182276, 64'd172225355691600141,
    64'd3034352936522087096, 64'd1266779576738385285, 64'd3906668377244742888,
    64'd6961783143042492788, 64'd17159706887321247572, 64'd4676208075243319061,
    64'd10315634697142985816, 64'd13435140047933251189, 64'd716076639492622016,
    64'd13847954035438697558, 64'd7195811275139178570, 64'd10815312636510328870,
    64'd6214164734784158515, 64'd16412194511839921544, 64'd3862249798930641332,
    64'd1005482699535576005, 64'd4644542796609371301, 64'd17600091057367987283,
    64'd4209958422564632034, 64'd5419285945389823940, 64'd11453701547564354601,
    64'd9951588026679380114, 64'd7425168333159839689, 64'd8436306210125134906,
    64'd11216615872596820107, 64'd3681345096403933680, 64'd5770016989916553752,
    64'd11102855936150871733, 64'd11187980892339693935, 64'd396336430216428875,
    64'd6384853777489155236, 64'd7551613839184151117, 64'd16527062023276943109,
    64'd13429850429024956898, 64'd9901753960477271766, 64'd9731501992702612259,
    64'd5217575797614661659, 64'd10311708346636548706, 64'd15111747519735330483,
    64'd4353415295139137513, 64'd1845293119018433391, 64'd11952006873430493561,
    64'd3531972641585683893, 64'd16852246477648409827, 64'd15956854822143321380,
    64'd12314609993579474774, 64'd16763911684844598963, 64'd16392145690385382634,
    64'd1545507136970403756, 64'd17771199061862790062, 64'd12121348462972638971,
    64'd12613068545148305776, 64'd954203144844315208, 64'd1257976447679270605,
    64'd3664184785462160180, 64'd2747964788443845091, 64'd15895917007470512307,
    64'd15552935765724302120, 64'd16366915862261682626, 64'd8385468783684865323,
    64'd10745343827145102946, 64'd2485742734157099909, 64'd916246281077683950,
    64'd15214206653637466707, 64'd12895483149474345798, 64'd1079510114301747843,
    64'd10718876134480663664, 64'd1259990987526807294, 64'd8326303777037206221,
    64'd14104661172014248293
  };

endpackage

// ----- rtl/tbh_if.sv -----
// valid/ready channel interfaces for input and result transactions
interface tbh_in_if;
  logic             valid;
  logic             ready;
  tbh_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tbh_out_if;
  logic              valid;
  logic              ready;
  tbh_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/table_byte_hash64_core.sv -----
// top level of the table driven 64-bit byte hash
//  channel | dir | fields                         | handshake
//  in_     | in  | data_byte start_req seed last  | valid/ready
//  out_    | out | hash_value is_final            | valid/ready
// one byte per cycle while the output takes results; result appears the cycle after its input transaction.
// the path is one rom read plus shift-xor into the accumulator register.
// synchronous reset clears the accumulator and the result valid.
// input is ready whenever the result register is empty or being taken.
module table_byte_hash64_core (
  input logic clk,
  input logic rst_n,
  tbh_in_if.sink    in_ch,
  tbh_out_if.source out_ch
);
  import tbh_pkg::*;

  hash_t acc_r;
  hash_t acc_nxt;
  logic  valid_r;
  logic  final_r;
  logic  take;

  assign in_ch.ready = !valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  tbh_step u_step (
    .acc     (acc_r),
    .item    (in_ch.payload),
    .acc_nxt (acc_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      valid_r <= 1'b0;
      final_r <= 1'b0;
    end else begin
      if (take) begin
        acc_r   <= acc_nxt;
        final_r <= in_ch.payload.last_byte;
        valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid              = valid_r;
  assign out_ch.payload.hash_value = acc_r;
  assign out_ch.payload.is_final   = final_r;
endmodule

// ----- rtl/tbh_step.sv -----
// one byte step of the hash: seed select, rom lookup, shift and xor
module tbh_step (
  input  tbh_pkg::hash_t acc,
  input  tbh_pkg::in_item_t item,
  output tbh_pkg::hash_t acc_nxt
);
  import tbh_pkg::*;

  hash_t base;
  byte_t idx;

  always_comb begin
    base    = item.start_req ? item.seed : acc;
    idx     = base[HashW-1 -: ByteW] ^ item.data_byte;
    acc_nxt = {base[HashW-ByteW-1:0], {ByteW{1'b0}}} ^ HASH_ROM[idx];
  end
endmodule
